[design/c2d_pkg.sv]
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared types and constants for the sliding-window 2d convolution block.
// ----------------------------------------------------------------------------
package c2d_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_KERNEL_DEF = 8;

  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int ACC_W    = 38;
  localparam int IDX_W    = 6;
  localparam int COORD_W  = 8;
  localparam int WIDTH_W  = 9;
  localparam int KSIZE_W  = 4;
  localparam int CFG_W    = WIDTH_W;
  localparam int CFG_IDX_W = 1;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 56;

  localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RST = 9'd256;
  localparam logic [KSIZE_W-1:0] KERNEL_SIZE_RST = 4'd3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE = 1'b1;

  localparam logic ACT_WEIGHT = 1'b0;
  localparam logic ACT_PIXEL  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // travels with each tap through the multiply-accumulate pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

[design/c2d_ram.sv]
// ----------------------------------------------------------------------------
// c2d_ram
// Simple dual-port memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module c2d_ram #(
  parameter int WIDTH = 16,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[design/c2d_mac.sv]
// ----------------------------------------------------------------------------
// c2d_mac
// Shared multiply-accumulate unit: registered product, then a 38-bit
// accumulator that restarts on the first tap of a window.
// ----------------------------------------------------------------------------
module c2d_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  c2d_pkg::mac_ctl_t                   ctl,
  input  logic signed [c2d_pkg::SAMPLE_W-1:0] pixel,
  input  logic signed [c2d_pkg::SAMPLE_W-1:0] weight,
  output logic signed [c2d_pkg::ACC_W-1:0]    acc,
  output logic                                done
);

  logic signed [c2d_pkg::PROD_W-1:0] prod;
  c2d_pkg::mac_ctl_t                 prod_ctl;

  always_ff @(posedge clk) begin
    prod <= pixel * weight;
    if (prod_ctl.valid) begin
      if (prod_ctl.first) begin
        acc <= c2d_pkg::ACC_W'(prod);
      end else begin
        acc <= acc + c2d_pkg::ACC_W'(prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_ctl <= '0;
      done     <= 1'b0;
    end else begin
      prod_ctl <= ctl;
      done     <= prod_ctl.valid & prod_ctl.last;
    end
  end

endmodule

[design/conv2d_valid_sliding_window_top.sv]
// ----------------------------------------------------------------------------
// conv2d_valid_sliding_window_top
// Valid 2d convolution at stride 1 over a square image, one shared MAC.
// ----------------------------------------------------------------------------
// Input stream s_*: tuser selects the item kind (0 = kernel weight, 1 = pixel).
// Weights load a tap by index; pixels arrive in raster order and go into a
// line buffer of the last MAX_KERNEL rows. A weight or a pixel that does not
// complete a window leaves the input ready for the next item. A pixel that
// completes a window starts a walk over k*k taps through one multiplier and
// accumulator: the input is not ready until the result enters the output
// register on m_*, as the line buffer has a single read port and there is a
// single MAC. tlast marks the last element of the feature map, after which
// the next pixel starts a new frame.
// A finished result waits in the output register while the receiver stalls;
// new items are still taken, and a following window finishes its sum but is
// held until the register is free.
// Reset (rst, synchronous) sets image_width 256 and kernel_size 3 and puts
// the frame at row 0, column 0. Kernel and line buffer contents are not
// cleared. Any configuration write also restarts the frame.
// ----------------------------------------------------------------------------
module conv2d_valid_sliding_window_top #(
  parameter int MAX_WIDTH  = c2d_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = c2d_pkg::MAX_KERNEL_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [c2d_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [c2d_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [c2d_pkg::S_DATA_W-1:0]    s_tdata,   // weight_index, sample_value, pad
  input  logic                            s_tuser,   // action
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [c2d_pkg::M_DATA_W-1:0]    m_tdata,   // map_value, map_row, map_col, pad
  output logic                            m_tlast
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = CW + 1;
  localparam int RW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int KW  = $clog2(MAX_KERNEL + 1) > 0 ? $clog2(MAX_KERNEL + 1) : 1;
  localparam int TAP = MAX_KERNEL * MAX_KERNEL;
  localparam int TAW = (TAP > 1) ? $clog2(TAP) : 1;
  localparam int LAW = RW + CW;

  // configuration
  logic [c2d_pkg::WIDTH_W-1:0] image_width;
  logic [c2d_pkg::KSIZE_W-1:0] kernel_size;
  logic [WW-1:0]               eff_w;
  logic [KW-1:0]               eff_k;

  // frame position
  logic [CW-1:0] pixel_row;
  logic [CW-1:0] pixel_col;
  logic [RW-1:0] lb_row;
  logic [CW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_lb;

  // sequencer
  c2d_pkg::state_t state;
  c2d_pkg::state_t state_next;
  logic [RW-1:0]   rd_row;
  logic [CW-1:0]   rd_col;
  logic [CW-1:0]   col_start;
  logic [KW-1:0]   n_cnt;
  logic [KW-1:0]   m_cnt;
  logic [TAW-1:0]  tap;
  logic            sum_ready;

  // result metadata
  logic [c2d_pkg::COORD_W-1:0] res_row;
  logic [c2d_pkg::COORD_W-1:0] res_col;
  logic                        res_last;

  logic                                s_accept;
  logic                                action;
  logic [c2d_pkg::IDX_W-1:0]           weight_index;
  logic [c2d_pkg::SAMPLE_W-1:0]        sample_value;
  logic                                pix_accept;
  logic                                wt_we;
  logic                                has_window;
  logic                                frame_end;
  logic                                tap_last;
  logic                                out_load;
  logic [RW-1:0]                       row_start;
  c2d_pkg::mac_ctl_t                   issue_ctl;
  c2d_pkg::mac_ctl_t                   mem_ctl;
  logic [c2d_pkg::SAMPLE_W-1:0]        lb_rdata;
  logic [c2d_pkg::SAMPLE_W-1:0]        wt_rdata;
  logic signed [c2d_pkg::ACC_W-1:0]    acc;
  logic                                mac_done;

  assign action       = s_tuser;
  assign weight_index = s_tdata[5:0];
  assign sample_value = s_tdata[21:6];
  assign s_tready     = (state == c2d_pkg::ST_IDLE);
  assign s_accept     = s_tvalid & s_tready;
  assign pix_accept   = s_accept & (action == c2d_pkg::ACT_PIXEL);
  assign wt_we        = s_accept & (action == c2d_pkg::ACT_WEIGHT) &
                        (32'(weight_index) < TAP);

  // clamp the geometry registers
  always_comb begin
    int w;
    int k;
    w = 32'(image_width);
    k = 32'(kernel_size);
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (k < 1) k = 1;
    if (k > MAX_KERNEL) k = MAX_KERNEL;
    if (k > w) k = w;
    eff_w = WW'(w);
    eff_k = KW'(k);
  end

  // positions left over from a larger geometry restart the frame
  always_comb begin
    if ((32'(pixel_row) >= 32'(eff_w)) || (32'(pixel_col) >= 32'(eff_w))) begin
      cur_row = '0;
      cur_col = '0;
      cur_lb  = '0;
    end else begin
      cur_row = pixel_row;
      cur_col = pixel_col;
      cur_lb  = lb_row;
    end
  end

  assign has_window = (32'(cur_row) + 1 >= 32'(eff_k)) && (32'(cur_col) + 1 >= 32'(eff_k));
  assign frame_end  = (32'(cur_row) + 1 == 32'(eff_w)) && (32'(cur_col) + 1 == 32'(eff_w));

  // oldest buffered row of the window, modulo the buffer height
  always_comb begin
    if (32'(cur_lb) >= 32'(eff_k) - 1) begin
      row_start = RW'(32'(cur_lb) - 32'(eff_k) + 1);
    end else begin
      row_start = RW'(32'(cur_lb) + MAX_KERNEL - 32'(eff_k) + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= c2d_pkg::IMAGE_WIDTH_RST;
      kernel_size <= c2d_pkg::KERNEL_SIZE_RST;
      pixel_row   <= '0;
      pixel_col   <= '0;
      lb_row      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        c2d_pkg::REG_IMAGE_WIDTH: image_width <= cfg_wdata;
        c2d_pkg::REG_KERNEL_SIZE: kernel_size <= cfg_wdata[c2d_pkg::KSIZE_W-1:0];
        default: ;
      endcase
      pixel_row <= '0;
      pixel_col <= '0;
      lb_row    <= '0;
    end else if (pix_accept) begin
      if (32'(cur_col) + 1 >= 32'(eff_w)) begin
        pixel_col <= '0;
        if (32'(cur_row) + 1 >= 32'(eff_w)) begin
          pixel_row <= '0;
          lb_row    <= '0;
        end else begin
          pixel_row <= cur_row + 1'b1;
          lb_row    <= (32'(cur_lb) == MAX_KERNEL - 1) ? '0 : RW'(32'(cur_lb) + 1);
        end
      end else begin
        pixel_col <= cur_col + 1'b1;
      end
    end
  end

  assign tap_last = (32'(m_cnt) + 1 == 32'(eff_k)) && (32'(n_cnt) + 1 == 32'(eff_k));

  always_comb begin
    issue_ctl.valid = (state == c2d_pkg::ST_RUN);
    issue_ctl.first = (tap == '0);
    issue_ctl.last  = tap_last;
  end

  assign out_load = (state == c2d_pkg::ST_DRAIN) && sum_ready && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    case (state)
      c2d_pkg::ST_IDLE: begin
        if (pix_accept && has_window) begin
          state_next = c2d_pkg::ST_RUN;
        end
      end
      c2d_pkg::ST_RUN: begin
        if (tap_last) begin
          state_next = c2d_pkg::ST_DRAIN;
        end
      end
      c2d_pkg::ST_DRAIN: begin
        if (out_load) begin
          state_next = c2d_pkg::ST_IDLE;
        end
      end
      default: state_next = c2d_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= c2d_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // window walk: columns inside a row, then the next buffered row
  always_ff @(posedge clk) begin
    if (state == c2d_pkg::ST_IDLE) begin
      rd_row    <= row_start;
      rd_col    <= CW'(32'(cur_col) + 1 - 32'(eff_k));
      col_start <= CW'(32'(cur_col) + 1 - 32'(eff_k));
      n_cnt     <= '0;
      m_cnt     <= '0;
      tap       <= '0;
      res_row   <= c2d_pkg::COORD_W'(32'(cur_row) + 1 - 32'(eff_k));
      res_col   <= c2d_pkg::COORD_W'(32'(cur_col) + 1 - 32'(eff_k));
      res_last  <= frame_end;
    end else if (state == c2d_pkg::ST_RUN) begin
      tap <= tap + 1'b1;
      if (32'(n_cnt) + 1 == 32'(eff_k)) begin
        n_cnt  <= '0;
        rd_col <= col_start;
        m_cnt  <= m_cnt + 1'b1;
        rd_row <= (32'(rd_row) == MAX_KERNEL - 1) ? '0 : RW'(32'(rd_row) + 1);
      end else begin
        n_cnt  <= n_cnt + 1'b1;
        rd_col <= rd_col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_ctl   <= '0;
      sum_ready <= 1'b0;
    end else begin
      mem_ctl <= issue_ctl;
      if (out_load) begin
        sum_ready <= 1'b0;
      end else if (mac_done) begin
        sum_ready <= 1'b1;
      end
    end
  end

  c2d_ram #(
    .WIDTH (c2d_pkg::SAMPLE_W),
    .AW    (LAW)
  ) u_line_buf (
    .clk   (clk),
    .we    (pix_accept),
    .waddr ({cur_lb, cur_col}),
    .wdata (sample_value),
    .raddr ({rd_row, rd_col}),
    .rdata (lb_rdata)
  );

  c2d_ram #(
    .WIDTH (c2d_pkg::SAMPLE_W),
    .AW    (TAW)
  ) u_weights (
    .clk   (clk),
    .we    (wt_we),
    .waddr (TAW'(weight_index)),
    .wdata (sample_value),
    .raddr (tap),
    .rdata (wt_rdata)
  );

  c2d_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mem_ctl),
    .pixel  (lb_rdata),
    .weight (wt_rdata),
    .acc    (acc),
    .done   (mac_done)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b00, res_col, res_row, acc};
      m_tlast <= res_last;
    end
  end

  // the accumulator only finishes while a window is draining
  assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == c2d_pkg::ST_DRAIN))
    else $error("mac finished outside drain");

  // a loaded result is always presented next cycle
  assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid)
    else $error("loaded result not presented");

  // a result waiting on a stalled receiver is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !out_load)
    else $error("output register overwritten while stalled");

  // the walk never leaves run before its last tap
  assert property (@(posedge clk) disable iff (rst)
    (state == c2d_pkg::ST_RUN && !tap_last) |=> (state == c2d_pkg::ST_RUN))
    else $error("window walk cut short");

endmodule
